>>> src/assert_macros.svh
// assertion macros shared by the route lookup rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every clock edge out of reset
`define LPM_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) else $error(msg);

// condition must never be seen out of reset
`define LPM_NEVER(lbl, clk, rstn, cond, msg) \
    `LPM_ASSERT(lbl, clk, rstn, !(cond), msg)

`endif

>>> src/lpm_pkg.sv
// shared types and codes of the longest prefix route lookup
package lpm_pkg;

    localparam logic ACT_WRITE  = 1'b0;
    localparam logic ACT_LOOKUP = 1'b1;

    typedef struct packed {
        logic        action;
        logic [6:0]  entry_index;
        logic [31:0] route_prefix;
        logic [31:0] route_mask;
        logic [31:0] route_next_hop;
        logic [1:0]  route_port;
        logic [31:0] dest_address;
    } in_t;

    typedef struct packed {
        logic        hit;
        logic [6:0]  hit_index;
        logic [31:0] hop_address;
        logic [1:0]  out_port;
    } out_t;

    typedef struct packed {
        logic [31:0] prefix;
        logic [31:0] mask;
        logic [31:0] gw_addr;
        logic [1:0]  port;
    } route_entry_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_LAST,
        ST_DONE
    } lpm_state_t;

    typedef struct packed {
        logic wr_en;
        logic rd_en;
    } tbl_ctrl_t;

    typedef struct packed {
        logic start;
        logic cmp_en;
    } mch_ctrl_t;

endpackage

>>> src/lpm_table.sv
// route table memory, one write port and one registered read port
module lpm_table #(
    parameter int DEPTH = 128,
    parameter int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic                  aclk,
    input  lpm_pkg::tbl_ctrl_t    ctrl,
    input  logic [IDX_W-1:0]      wr_addr,
    input  lpm_pkg::route_entry_t wr_data,
    input  logic [IDX_W-1:0]      rd_addr,
    output lpm_pkg::route_entry_t rd_data
);
    import lpm_pkg::*;

    route_entry_t table_mem [DEPTH];
    route_entry_t rd_data_reg;

    always_ff @(posedge aclk) begin
        if (ctrl.wr_en) begin
            table_mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (ctrl.rd_en) begin
            rd_data_reg <= table_mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

>>> src/lpm_match.sv
// shared compare unit that keeps the best matching route
`include "assert_macros.svh"
module lpm_match #(
    parameter int DEPTH = 128,
    parameter int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  lpm_pkg::mch_ctrl_t    ctrl,
    input  logic [31:0]           start_dest,
    input  logic [IDX_W-1:0]      cmp_idx,
    input  lpm_pkg::route_entry_t entry,
    output lpm_pkg::out_t         result
);
    import lpm_pkg::*;

    logic [31:0]      dest_reg;
    logic             found_reg;
    logic [31:0]      best_mask_reg;
    logic [IDX_W-1:0] best_idx_reg;
    logic [31:0]      hop_reg;
    logic [1:0]       port_reg;

    logic match;
    logic take;

    always_comb begin
        match = ((entry.mask & dest_reg) == entry.prefix);
        take  = ctrl.cmp_en && match && (!found_reg || (entry.mask > best_mask_reg));
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            found_reg <= 1'b0;
        end else if (ctrl.start) begin
            found_reg <= 1'b0;
        end else if (take) begin
            found_reg <= 1'b1;
        end
    end

    // a miss reports zeros, so the payload is cleared on start
    always_ff @(posedge aclk) begin
        if (ctrl.start) begin
            dest_reg      <= start_dest;
            best_mask_reg <= '0;
            best_idx_reg  <= '0;
            hop_reg       <= '0;
            port_reg      <= '0;
        end else if (take) begin
            best_mask_reg <= entry.mask;
            best_idx_reg  <= cmp_idx;
            hop_reg       <= entry.gw_addr;
            port_reg      <= entry.port;
        end
    end

    always_comb begin
        result.hit         = found_reg;
        result.hit_index   = 7'(best_idx_reg);
        result.hop_address = hop_reg;
        result.out_port    = port_reg;
    end

    `LPM_ASSERT(a_match_sets_found, aclk, aresetn,
        (ctrl.cmp_en && !ctrl.start && match) |=> found_reg,
        "matching entry left found clear")

endmodule

>>> src/lpm_seq.sv
// sequencer that walks the table one entry per cycle
`include "assert_macros.svh"
module lpm_seq #(
    parameter int DEPTH = 128,
    parameter int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic               item_action,
    input  logic [6:0]         item_index,
    input  logic [7:0]         cfg_count,
    input  logic               m_busy,
    output lpm_pkg::tbl_ctrl_t tbl_ctrl,
    output logic [IDX_W-1:0]   rd_addr,
    output lpm_pkg::mch_ctrl_t mch_ctrl,
    output logic [IDX_W-1:0]   cmp_idx,
    output logic               out_load
);
    import lpm_pkg::*;

    lpm_state_t       state_reg, state_next;
    logic [IDX_W-1:0] scan_idx_reg, scan_idx_next;
    logic [IDX_W-1:0] last_idx_reg, last_idx_next;
    logic             cmp_vld_reg, cmp_vld_next;
    logic [IDX_W-1:0] cmp_idx_reg, cmp_idx_next;

    logic        accept;
    logic        is_lookup;
    logic        in_range;
    logic        lim_zero;
    logic [31:0] lim;

    always_comb begin
        accept    = s_valid && (state_reg == ST_IDLE);
        is_lookup = (item_action == ACT_LOOKUP);
        in_range  = (32'(item_index) < 32'(DEPTH));
        lim       = (32'(cfg_count) > 32'(DEPTH)) ? 32'(DEPTH) : 32'(cfg_count);
        lim_zero  = (lim == 32'd0);
    end

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    state_next = (is_lookup && !lim_zero) ? ST_SCAN : ST_DONE;
                end
            end
            ST_SCAN: begin
                if (scan_idx_reg == last_idx_reg) begin
                    state_next = ST_LAST;
                end
            end
            ST_LAST: begin
                state_next = ST_DONE;
            end
            ST_DONE: begin
                if (!m_busy) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // scan counter and compare stage
    always_comb begin
        scan_idx_next = scan_idx_reg;
        last_idx_next = last_idx_reg;
        if (accept) begin
            scan_idx_next = '0;
            last_idx_next = IDX_W'(lim - 32'd1);
        end else if (state_reg == ST_SCAN) begin
            scan_idx_next = scan_idx_reg + 1'b1;
        end
        cmp_vld_next = (state_reg == ST_SCAN);
        cmp_idx_next = scan_idx_reg;
    end

    // outputs
    always_comb begin
        s_ready         = (state_reg == ST_IDLE);
        tbl_ctrl.wr_en  = accept && !is_lookup && in_range;
        tbl_ctrl.rd_en  = (state_reg == ST_SCAN);
        rd_addr         = scan_idx_reg;
        mch_ctrl.start  = accept;
        mch_ctrl.cmp_en = cmp_vld_reg;
        cmp_idx         = cmp_idx_reg;
        out_load        = (state_reg == ST_DONE) && !m_busy;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            cmp_vld_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            cmp_vld_reg <= cmp_vld_next;
        end
    end

    always_ff @(posedge aclk) begin
        scan_idx_reg <= scan_idx_next;
        last_idx_reg <= last_idx_next;
        cmp_idx_reg  <= cmp_idx_next;
    end

    `LPM_ASSERT(a_scan_in_bounds, aclk, aresetn,
        (state_reg == ST_SCAN) |-> (scan_idx_reg <= last_idx_reg),
        "scan index ran past the last entry")
    `LPM_ASSERT(a_cmp_in_scan, aclk, aresetn,
        cmp_vld_reg |-> (state_reg == ST_SCAN || state_reg == ST_LAST),
        "compare outside of a scan")

endmodule

>>> src/longest_prefix_route_lookup_top.sv
// top level of the longest prefix route lookup over a linear table
// lookup: scans entries 0 to limit-1, limit = min(entry_count, DEPTH), then registers the result
// write item or lookup with limit 0: no scan, the result goes straight to the output register
// a new item is taken only once the result of the last one is loaded into the output register
// one entry read and compared per cycle; a stalled result holds off the next item
// reset clears control state and entry_count; the table is not cleared
`include "assert_macros.svh"
module longest_prefix_route_lookup_top #(
    parameter int DEPTH = 128
) (
    input  logic          aclk,
    input  logic          aresetn,
    // input item channel
    input  logic          s_valid,
    output logic          s_ready,
    input  lpm_pkg::in_t  s_data,
    // result item channel
    output logic          m_valid,
    input  logic          m_ready,
    output lpm_pkg::out_t m_data,
    // entry_count register write
    input  logic          cfg_we,
    input  logic [7:0]    cfg_wdata
);
    import lpm_pkg::*;

    localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    // configuration register
    logic [7:0] cfg_count_reg;

    // output register, parts the result side from the sequencer
    logic m_valid_reg;
    out_t m_data_reg;
    logic m_busy;

    // internal connections
    tbl_ctrl_t        tbl_ctrl;
    mch_ctrl_t        mch_ctrl;
    logic [IDX_W-1:0] rd_addr;
    logic [IDX_W-1:0] cmp_idx;
    logic             out_load;
    route_entry_t     wr_entry;
    route_entry_t     rd_entry;
    out_t             result;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_count_reg <= 8'd0;
        end else if (cfg_we) begin
            cfg_count_reg <= cfg_wdata;
        end
    end

    // result slot is held while the consumer stalls
    assign m_busy = m_valid_reg && !m_ready;

    // entry image of a write item
    always_comb begin
        wr_entry.prefix  = s_data.route_prefix;
        wr_entry.mask    = s_data.route_mask;
        wr_entry.gw_addr = s_data.route_next_hop;
        wr_entry.port    = s_data.route_port;
    end

    // fsm, scan counter and compare stage timing
    lpm_seq #(
        .DEPTH (DEPTH),
        .IDX_W (IDX_W)
    ) u_seq (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .item_action (s_data.action),
        .item_index  (s_data.entry_index),
        .cfg_count   (cfg_count_reg),
        .m_busy      (m_busy),
        .tbl_ctrl    (tbl_ctrl),
        .rd_addr     (rd_addr),
        .mch_ctrl    (mch_ctrl),
        .cmp_idx     (cmp_idx),
        .out_load    (out_load)
    );

    // route table, written at the accept edge of a write item with an in-range index
    lpm_table #(
        .DEPTH (DEPTH),
        .IDX_W (IDX_W)
    ) u_table (
        .aclk    (aclk),
        .ctrl    (tbl_ctrl),
        .wr_addr (IDX_W'(s_data.entry_index)),
        .wr_data (wr_entry),
        .rd_addr (rd_addr),
        .rd_data (rd_entry)
    );

    // masked compare and best mask tracking, one entry per cycle
    lpm_match #(
        .DEPTH (DEPTH),
        .IDX_W (IDX_W)
    ) u_match (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .ctrl       (mch_ctrl),
        .start_dest (s_data.dest_address),
        .cmp_idx    (cmp_idx),
        .entry      (rd_entry),
        .result     (result)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (out_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            m_data_reg <= result;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    // an accepted item always leaves ready low in the next cycle
    `LPM_ASSERT(a_busy_after_accept, aclk, aresetn,
        (s_valid && s_ready) |=> !s_ready,
        "ready stayed high after an item was taken")

endmodule

>>> verif/route_lookup_checker.sv
// checker of the route lookup: mirrors the route table, predicts and compares every result item
module route_lookup_checker #(
    parameter int DEPTH = 128
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_valid,
    input  logic          s_ready,
    input  lpm_pkg::in_t  s_data,
    input  logic          m_valid,
    input  logic          m_ready,
    input  lpm_pkg::out_t m_data,
    input  logic          cfg_we,
    input  logic [7:0]    cfg_wdata,
    output int            mismatches,
    output int            pending_results,
    output int            lookups_seen,
    output int            hits_seen
);
    timeunit 1ns;
    timeprecision 1ps;

    import lpm_pkg::*;

    localparam int REPORT_LIMIT = 10;

    route_entry_t route_mirror [DEPTH];
    logic [7:0]   scan_count;
    out_t         pending_decisions [$];

    // write items update the mirror, lookups pick the numerically largest matching mask, first slot on ties
    function automatic out_t route_decision(input in_t item);
        out_t         res;
        route_entry_t entry;
        int           scan;
        logic         found;
        logic [31:0]  best_mask;
        logic [6:0]   best_slot;
        res       = '0;
        found     = 1'b0;
        best_mask = '0;
        best_slot = '0;
        if (item.action == ACT_WRITE) begin
            entry.prefix  = item.route_prefix;
            entry.mask    = item.route_mask;
            entry.gw_addr = item.route_next_hop;
            entry.port    = item.route_port;
            if (int'(item.entry_index) < DEPTH) route_mirror[item.entry_index] = entry;
            return res;
        end
        scan = (int'(scan_count) > DEPTH) ? DEPTH : int'(scan_count);
        for (int i = 0; i < scan; i++) begin
            if ((route_mirror[i].mask & item.dest_address) == route_mirror[i].prefix &&
                (!found || route_mirror[i].mask > best_mask)) begin
                found     = 1'b1;
                best_mask = route_mirror[i].mask;
                best_slot = 7'(i);
            end
        end
        if (found) begin
            res.hit         = 1'b1;
            res.hit_index   = best_slot;
            res.hop_address = route_mirror[best_slot].gw_addr;
            res.out_port    = route_mirror[best_slot].port;
        end
        return res;
    endfunction

    task automatic report_mismatch(input string what, input out_t want, input out_t got);
        mismatches++;
        if (mismatches <= REPORT_LIMIT) begin
            $display("%t result item %s: expected hit=%0b index=%0d hop=%h port=%0d,",
                     $realtime, what, want.hit, want.hit_index, want.hop_address, want.out_port,
                     " got hit=%0b index=%0d hop=%h port=%0d",
                     got.hit, got.hit_index, got.hop_address, got.out_port);
        end
    endtask

    always @(posedge aclk) begin : watch_channels
        out_t want;
        out_t got;
        if (!aresetn) begin
            scan_count = '0;
            pending_decisions.delete();
            pending_results = 0;
        end else begin
            if (cfg_we) scan_count = cfg_wdata;
            // results first: an item taken at this edge cannot have its result here yet
            if (m_valid && m_ready) begin
                got = m_data;
                if (pending_decisions.size() == 0) begin
                    report_mismatch("with nothing outstanding", '0, got);
                end else begin
                    want = pending_decisions.pop_front();
                    if (got.hit !== want.hit || got.hit_index !== want.hit_index ||
                        got.hop_address !== want.hop_address ||
                        got.out_port !== want.out_port) begin
                        report_mismatch("differs", want, got);
                    end
                end
            end
            if (s_valid && s_ready) begin
                want = route_decision(s_data);
                if (s_data.action == ACT_LOOKUP) begin
                    lookups_seen++;
                    if (want.hit) hits_seen++;
                end
                pending_decisions.push_back(want);
            end
            pending_results = pending_decisions.size();
        end
    end

endmodule

>>> verif/tb.sv
// testbench top of the route lookup: clock, reset, stimulus, flow control and verdict
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import lpm_pkg::*;

    localparam int DEPTH          = 128;
    localparam int CLK_PERIOD     = 10;
    localparam int RESET_CYCLES   = 5;
    // wait after the last result is taken, so the block is back at idle before the count changes
    localparam int SETTLE_CYCLES  = 4;
    // long receiver hold-off so the block backs up into its input
    localparam int HOLD_CYCLES    = 300;
    // a full scan plus margin, waited out once everything has come back
    localparam int DRAIN_CYCLES   = DEPTH + 8;
    // covers the slowest lookup, plus bursts and the hold-off, several times over
    localparam int STALL_LIMIT    = 3000;
    localparam int NUM_PHASES     = 9;
    localparam int PHASE_ITEMS    = 90;
    localparam int PRESSURE_PHASE = 3;

    logic       aclk      = 1'b0;
    logic       aresetn   = 1'b0;
    logic       s_valid   = 1'b0;
    logic       s_ready;
    in_t        s_data    = '0;
    logic       m_valid;
    logic       m_ready   = 1'b0;
    out_t       m_data;
    logic       cfg_we    = 1'b0;
    logic [7:0] cfg_wdata = '0;

    int mismatches;
    int pending_results;
    int lookups_seen;
    int hits_seen;

    // flow control knobs of the sender and the receiver
    int tx_idle_pct = 0;
    int rx_idle_pct = 0;
    int hold_reqs   = 0;

    // bookkeeping for steering lookups at known routes (not used for checking)
    logic [7:0]  cur_count = '0;
    logic [31:0] aim_prefix [DEPTH];
    logic [31:0] aim_mask   [DEPTH];
    logic [31:0] route_bases [4];
    int          sent_items     = 0;
    int          count_settings = 0;

    always #(CLK_PERIOD / 2) aclk = ~aclk;

    longest_prefix_route_lookup_top #(
        .DEPTH(DEPTH)
    ) u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_valid  (s_valid),
        .s_ready  (s_ready),
        .s_data   (s_data),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_data   (m_data),
        .cfg_we   (cfg_we),
        .cfg_wdata(cfg_wdata)
    );

    route_lookup_checker #(
        .DEPTH(DEPTH)
    ) u_checker (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_data         (s_data),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_data         (m_data),
        .cfg_we         (cfg_we),
        .cfg_wdata      (cfg_wdata),
        .mismatches     (mismatches),
        .pending_results(pending_results),
        .lookups_seen   (lookups_seen),
        .hits_seen      (hits_seen)
    );

    // every field but action random (action is lookup); callers overwrite what matters for the action
    function automatic in_t noise_item();
        in_t item;
        item.action         = ACT_LOOKUP;
        item.entry_index    = 7'($urandom());
        item.route_prefix   = $urandom();
        item.route_mask     = $urandom();
        item.route_next_hop = $urandom();
        item.route_port     = 2'($urandom());
        item.dest_address   = $urandom();
        return item;
    endfunction

    // an address close to one of a few bases, so routes overlap and compete
    function automatic logic [31:0] near_base();
        return route_bases[$urandom_range(0, 3)] ^ ($urandom() >> $urandom_range(4, 32));
    endfunction

    function automatic int idle_choice();
        case ($urandom_range(0, 2))
            0: return 0;
            1: return 5;
            default: return 15;
        endcase
    endfunction

    function automatic in_t route_item(input logic [6:0] slot, input logic [31:0] prefix,
                                       input logic [31:0] mask, input logic [31:0] hop,
                                       input logic [1:0] port);
        in_t item;
        item                = noise_item();
        item.action         = ACT_WRITE;
        item.entry_index    = slot;
        item.route_prefix   = prefix;
        item.route_mask     = mask;
        item.route_next_hop = hop;
        item.route_port     = port;
        return item;
    endfunction

    function automatic in_t lookup_item(input logic [31:0] dest);
        in_t item;
        item              = noise_item();
        item.dest_address = dest;
        return item;
    endfunction

    // mostly proper prefixes with contiguous masks, some odd masks and stray prefix bits
    function automatic in_t make_route(input logic [6:0] slot);
        in_t         item;
        int unsigned plen;
        int          pick;
        item             = noise_item();
        item.action      = ACT_WRITE;
        item.entry_index = slot;
        pick             = $urandom_range(0, 99);
        if (pick < 90) begin
            plen              = $urandom_range(0, 32);
            item.route_mask   = (plen == 0) ? 32'h0 : (32'hFFFF_FFFF << (32 - plen));
            item.route_prefix = near_base() & item.route_mask;
        end else if (pick < 95) begin
            // non-contiguous mask, prefix inside it
            item.route_prefix = item.route_prefix & item.route_mask;
        end
        // otherwise both stay random: prefix bits almost surely outside the mask
        return item;
    endfunction

    // mostly aimed at a scanned route, some near the bases, some anywhere
    function automatic in_t make_lookup();
        in_t item;
        int  scan;
        int  slot;
        int  pick;
        item = noise_item();
        scan = (int'(cur_count) > DEPTH) ? DEPTH : int'(cur_count);
        pick = $urandom_range(0, 99);
        if (pick < 70 && scan > 0) begin
            slot              = $urandom_range(0, scan - 1);
            item.dest_address = aim_prefix[slot] | (item.dest_address & ~aim_mask[slot]);
        end else if (pick < 85) begin
            item.dest_address = near_base();
        end
        return item;
    endfunction

    // offer one item and hold it until taken; valid stays up for a back-to-back item
    task automatic offer_item(input in_t item);
        if (tx_idle_pct != 0 && $urandom_range(0, 99) < tx_idle_pct) begin
            s_valid = 1'b0;
            repeat ($urandom_range(1, 10)) @(negedge aclk);
        end
        s_data  = item;
        s_valid = 1'b1;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        if (item.action == ACT_WRITE) begin
            aim_prefix[item.entry_index] = item.route_prefix;
            aim_mask[item.entry_index]   = item.route_mask;
        end
        sent_items++;
        @(negedge aclk);
    endtask

    // entry_count only changes with the block drained and idle
    task automatic set_entry_count(input logic [7:0] count);
        s_valid = 1'b0;
        while (pending_results != 0) @(negedge aclk);
        repeat (SETTLE_CYCLES) @(negedge aclk);
        cfg_wdata = count;
        cfg_we    = 1'b1;
        @(negedge aclk);
        cfg_we    = 1'b0;
        cur_count = count;
        count_settings++;
    endtask

    // result side: random stall bursts, plus one long hold-off on request
    initial begin : result_sink
        int seen;
        seen = 0;
        forever begin
            @(negedge aclk);
            if (hold_reqs != seen) begin
                seen    = hold_reqs;
                m_ready = 1'b0;
                repeat (HOLD_CYCLES - 1) @(negedge aclk);
            end else if (rx_idle_pct != 0 && $urandom_range(0, 99) < rx_idle_pct) begin
                m_ready = 1'b0;
                repeat ($urandom_range(1, 10) - 1) @(negedge aclk);
            end else begin
                m_ready = 1'b1;
            end
        end
    end

    // ends the run when no item moves on either channel for too long
    initial begin : watchdog
        int quiet_cycles;
        quiet_cycles = 0;
        while (quiet_cycles < STALL_LIMIT) begin
            @(posedge aclk);
            if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
                quiet_cycles = 0;
            end else begin
                quiet_cycles++;
            end
        end
        $display("watchdog: no item moved for %0d cycles, %0d results outstanding",
                 STALL_LIMIT, pending_results);
        $display("CHECK FAILED");
        $finish;
    end

    initial begin : stimulus
        logic [7:0] phase_counts [NUM_PHASES];
        logic       last_phase;
        foreach (route_bases[i]) route_bases[i] = $urandom();
        // zero, full table, saturating counts, tiny and mid-sized scans
        phase_counts = '{8'd128, 8'd0, 8'd255, 8'd16, 8'd1, 8'd129,
                         8'($urandom_range(2, 127)), 8'd64, 8'd128};

        repeat (RESET_CYCLES) @(negedge aclk);
        aresetn = 1'b1;

        // empty scan right after reset: both lookups miss
        offer_item(lookup_item(32'h0000_0000));
        offer_item(lookup_item(32'hFFFF_FFFF));

        // a small table: default route, nested prefixes, a tie, an odd mask, a dead entry, the top slot
        offer_item(route_item(7'd0, 32'h0000_0000, 32'h0000_0000, 32'h0A00_0001, 2'd1));
        offer_item(route_item(7'd1, 32'h0A00_0000, 32'hFF00_0000, 32'hFFFF_FFFF, 2'd3));
        offer_item(route_item(7'd2, 32'h0A01_0000, 32'hFFFF_0000, 32'h0000_0000, 2'd0));
        offer_item(route_item(7'd3, 32'h0A01_0200, 32'hFFFF_FF00, 32'h0A01_02FE, 2'd2));
        offer_item(route_item(7'd4, 32'h0A01_0203, 32'hFFFF_FFFF, 32'h0A01_0203, 2'd3));
        // same prefix and mask as slot 2: the lower slot must win
        offer_item(route_item(7'd5, 32'h0A01_0000, 32'hFFFF_0000, 32'h5555_AAAA, 2'd1));
        // non-contiguous mask, ranked by its numeric value
        offer_item(route_item(7'd6, 32'h0A00_0200, 32'hFF00_FF00, 32'hAAAA_5555, 2'd2));
        // prefix has host bits set, so this entry can never match
        offer_item(route_item(7'd7, 32'hC0A8_0101, 32'hFFFF_FF00, 32'hDEAD_0007, 2'd0));
        // top slot with every field at its maximum
        offer_item(route_item(7'd127, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 2'd3));

        set_entry_count(8'd8);
        offer_item(lookup_item(32'h0A01_0203));   // host route
        offer_item(lookup_item(32'h0A01_0209));   // /24
        offer_item(lookup_item(32'h0A01_0909));   // /16 tie
        offer_item(lookup_item(32'h0A09_0209));   // odd mask beats the /8
        offer_item(lookup_item(32'h0A09_0909));   // /8
        offer_item(lookup_item(32'hC0A8_0101));   // dead entry skipped, default route
        offer_item(lookup_item(32'hFFFF_FFFF));   // default route only

        // a single scanned slot: only the default route is seen
        set_entry_count(8'd1);
        offer_item(lookup_item(32'h0A01_0203));

        // fill the rest of the table with lookups on the first eight slots mixed in
        set_entry_count(8'd8);
        tx_idle_pct = idle_choice();
        rx_idle_pct = idle_choice();
        for (int slot = 8; slot < DEPTH - 1; slot++) begin
            if ($urandom_range(0, 99) < 30) offer_item(make_lookup());
            offer_item(make_route(7'(slot)));
        end

        // every slot is written now, so any count is safe from here on
        for (int p = 0; p < NUM_PHASES; p++) begin
            set_entry_count(phase_counts[p]);
            last_phase  = (p == NUM_PHASES - 1);
            tx_idle_pct = last_phase ? 0 : idle_choice();
            rx_idle_pct = last_phase ? 0 : idle_choice();
            if (p == PRESSURE_PHASE) begin
                // keep offering while results are held back
                tx_idle_pct = 0;
                hold_reqs++;
            end
            repeat (PHASE_ITEMS) begin
                if ($urandom_range(0, 99) < 60) begin
                    offer_item(make_lookup());
                end else begin
                    offer_item(make_route(7'($urandom_range(0, DEPTH - 1))));
                end
            end
        end

        s_valid = 1'b0;
        while (pending_results != 0) @(negedge aclk);
        repeat (DRAIN_CYCLES) @(negedge aclk);

        $display("run covered %0d items: %0d lookups (%0d hits), %0d entry_count settings,",
                 sent_items, lookups_seen, hits_seen, count_settings,
                 " a %0d-cycle result hold-off; %0d mismatches", HOLD_CYCLES, mismatches);
        if (mismatches == 0 && pending_results == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

>>> longest_prefix_route_lookup_top.f
+incdir+src
src/lpm_pkg.sv
src/lpm_table.sv
src/lpm_match.sv
src/lpm_seq.sv
src/longest_prefix_route_lookup_top.sv
verif/route_lookup_checker.sv
verif/tb.sv
